[src/skf_pkg.sv]
// Shared constants and types of the scalar Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 8'd1;

   // Sequencer states of the filter update.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIOR,
      ST_DIVIDE,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_COV,
      ST_OUT
   } state_type;

   // Status reported by the gain divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[src/skf_if.sv]
// Handshake channel interfaces of the scalar Kalman filter.
`timescale 1ns / 1ps

interface skf_req_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_rsp_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;

   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_csr_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
   logic                                  valid;
   logic                                  ready;
   logic [skf_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [DATA_WIDTH-1:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/skf_div.sv]
// Restoring divider that forms the fractional Kalman gain, one bit per cycle.
`timescale 1ns / 1ps

module skf_div #(
   parameter int DEN_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT + 4,
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DEN_WIDTH-1:0]      num,
   input  logic [DEN_WIDTH-1:0]      den,
   output skf_pkg::div_status_type   status,
   output logic [FRAC_BITS:0]        quotient
);

   localparam int CNT_WIDTH = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [FRAC_BITS:0]   quo_ff, quo_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [DEN_WIDTH:0]   shifted;
   logic [DEN_WIDTH:0]   den_ext;
   logic [DEN_WIDTH:0]   diff;
   logic                 fits;

   assign shifted = {rem_ff, 1'b0};
   assign den_ext = {1'b0, den_ff};
   assign diff    = shifted - den_ext;
   assign fits    = (shifted >= den_ext);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = den;
         if (num >= den) begin
            // The prior covers the whole denominator: the gain is one.
            quo_in  = GAIN_ONE;
            done_in = 1'b1;
            run_in  = 1'b0;
         end else begin
            rem_in = num;
            quo_in = '0;
            cnt_in = CNT_WIDTH'(FRAC_BITS);
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (fits) begin
            rem_in = diff[DEN_WIDTH-1:0];
         end else begin
            rem_in = shifted[DEN_WIDTH-1:0];
         end
         quo_in = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

[src/skf_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module skf_mul #(
   parameter int A_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT + 4,
   parameter int B_WIDTH = skf_pkg::FRAC_BITS_DEFAULT + 2
) (
   input  logic                               clock,
   input  logic signed [A_WIDTH-1:0]          a,
   input  logic signed [B_WIDTH-1:0]          b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]  product
);

   logic signed [A_WIDTH+B_WIDTH-1:0] product_ff, product_in;

   assign product_in = $signed(A_WIDTH'(a)) * $signed(B_WIDTH'(b));

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[src/scalar_kalman_filter.sv]
// Top level of the scalar constant-state Kalman filter in fixed point.
//
//   Channel  Direction  Payload                          Meaning
//   req      in         measurement (signed Q.FRAC)      new raw measurement
//   rsp      out        estimate    (signed Q.FRAC)      updated filtered estimate
//   csr      in         index, data                      process / measurement noise
//
// Each item steps through the states prior, divide, estimate multiply,
// covariance multiply, covariance and output before the next is accepted. The
// gain divider retires one quotient bit per cycle (FRAC_BITS bits; the default
// format is Q16.16). When the measurement noise is zero the gain is one at once.
// Reset (synchronous) clears the estimate, sets the covariance to 20.0 and
// restores the noise registers to 0.01 and 1.0. No channel accepts during reset.
// The result sits in an output register, so a new item is taken while it
// waits; only a second finished result stalls the sequencer until rsp drains.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEFAULT,
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   skf_req_if.sink   req,
   skf_rsp_if.source rsp,
   skf_csr_if.sink   csr
);

   // Widths of the intermediate quantities.
   localparam int W   = DATA_WIDTH;
   localparam int CW  = W + 2;          // covariance
   localparam int PW  = W + 3;          // prior covariance
   localparam int DW  = W + 4;          // gain denominator
   localparam int EW  = W + 1;          // innovation (measurement error)
   localparam int GW  = FRAC_BITS + 1;  // gain, unsigned, up to one
   localparam int AW  = W + 4;          // multiplier operand a
   localparam int BW  = FRAC_BITS + 2;  // multiplier operand b
   localparam int PRW = AW + BW;        // product

   localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0] COV_MAX  = {CW{1'b1}};
   localparam logic [CW-1:0] COV_RESET = CW'(20) << FRAC_BITS;
   localparam logic [W-1:0]  PROCESS_NOISE_RESET = W'((64'd1 << FRAC_BITS) / 100);
   localparam logic [W-1:0]  MEASUREMENT_NOISE_RESET = W'(1) << FRAC_BITS;

   // Configuration registers.
   logic [W-1:0] process_noise_ff;
   logic [W-1:0] measurement_noise_ff;

   // Filter state and per-item working registers.
   skf_pkg::state_type state_ff, state_in;
   logic signed [W-1:0]  estimate_ff, estimate_in;
   logic [CW-1:0]        covariance_ff, covariance_in;
   logic signed [W-1:0]  meas_ff;
   logic [PW-1:0]        prior_ff;

   // Output register.
   logic                 rsp_valid_ff;
   logic signed [W-1:0]  rsp_estimate_ff;

   // Sequencer controls.
   logic req_accept;
   logic div_start;
   logic mul_sel_cov;
   logic est_load;
   logic cov_load;
   logic out_load;
   logic out_free;

   // Datapath signals.
   logic [PW-1:0]            prior_sum;
   logic [DW-1:0]            den_sum;
   logic signed [EW-1:0]     err_diff;
   skf_pkg::div_status_type  div_status;
   logic [GW-1:0]            gain;
   logic [GW-1:0]            gain_rest;
   logic signed [AW-1:0]     mul_a;
   logic signed [BW-1:0]     mul_b;
   logic signed [PRW-1:0]    product;
   logic signed [PRW-1:0]    product_shift;
   logic signed [PRW-1:0]    estimate_sum;

   assign req_accept = req.valid && req.ready;
   assign req.ready  = (state_ff == skf_pkg::ST_IDLE) && !reset;
   assign csr.ready  = !reset;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // Configuration writes; an index outside the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff     <= PROCESS_NOISE_RESET;
         measurement_noise_ff <= MEASUREMENT_NOISE_RESET;
      end else if (csr.valid && csr.ready) begin
         if (csr.index == skf_pkg::CSR_PROCESS_NOISE) begin
            process_noise_ff <= csr.data;
         end
         if (csr.index == skf_pkg::CSR_MEASUREMENT_NOISE) begin
            measurement_noise_ff <= csr.data;
         end
      end
   end

   // Prior covariance, gain denominator and innovation.
   assign prior_sum = {1'b0, covariance_ff} + {3'b000, process_noise_ff};
   assign den_sum   = {1'b0, prior_ff} + {4'b0000, measurement_noise_ff};
   assign err_diff  = {meas_ff[W-1], meas_ff} - {estimate_ff[W-1], estimate_ff};

   skf_div #(
      .DEN_WIDTH (DW),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      ({1'b0, prior_ff}),
      .den      (den_sum),
      .status   (div_status),
      .quotient (gain)
   );

   // The one multiplier serves both the estimate step and the covariance step.
   assign gain_rest = GAIN_ONE - gain;
   always_comb begin
      if (mul_sel_cov) begin
         mul_a = $signed({1'b0, prior_ff});
         mul_b = $signed({1'b0, gain_rest});
      end else begin
         mul_a = $signed({{(AW - EW){err_diff[EW-1]}}, err_diff});
         mul_b = $signed({1'b0, gain});
      end
   end

   skf_mul #(
      .A_WIDTH (AW),
      .B_WIDTH (BW)
   ) u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   // An arithmetic shift floors the scaled product, so a negative innovation
   // moves the estimate down by the rounded-up magnitude.
   assign product_shift = product >>> FRAC_BITS;
   assign estimate_sum  = $signed({{(PRW - W){estimate_ff[W-1]}}, estimate_ff})
                          + product_shift;
   assign estimate_in   = estimate_sum[W-1:0];

   // The new covariance never exceeds the prior; it saturates at its top value.
   assign covariance_in = (|product_shift[PRW-1:CW]) ? COV_MAX : product_shift[CW-1:0];

   // Sequencer: next state and controls.
   always_comb begin
      state_in    = state_ff;
      div_start   = 1'b0;
      mul_sel_cov = 1'b0;
      est_load    = 1'b0;
      cov_load    = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         skf_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = skf_pkg::ST_PRIOR;
            end
         end
         skf_pkg::ST_PRIOR: begin
            div_start = 1'b1;
            state_in  = skf_pkg::ST_DIVIDE;
         end
         skf_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = skf_pkg::ST_MUL_EST;
            end
         end
         skf_pkg::ST_MUL_EST: begin
            state_in = skf_pkg::ST_MUL_COV;
         end
         skf_pkg::ST_MUL_COV: begin
            mul_sel_cov = 1'b1;
            est_load    = 1'b1;
            state_in    = skf_pkg::ST_COV;
         end
         skf_pkg::ST_COV: begin
            cov_load = 1'b1;
            state_in = skf_pkg::ST_OUT;
         end
         skf_pkg::ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = skf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Filter state and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         estimate_ff   <= '0;
         covariance_ff <= COV_RESET;
      end else begin
         if (est_load) begin
            estimate_ff <= estimate_in;
         end
         if (cov_load) begin
            covariance_ff <= covariance_in;
         end
      end
      if (req_accept) begin
         meas_ff  <= req.measurement;
         prior_ff <= prior_sum;
      end
   end

   // Output register: holds one finished item until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_estimate_ff <= estimate_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.estimate = rsp_estimate_ff;

endmodule
